>>> rtl/zero_crossing_clock_recovery_macros.svh
// Assertion macros shared by the blocks that check themselves.
// Every macro samples on clk_i and is switched off while rst_ni is low.
`ifndef ZERO_CROSSING_CLOCK_RECOVERY_MACROS_SVH
`define ZERO_CROSSING_CLOCK_RECOVERY_MACROS_SVH

// A property that must hold at every clock edge.
`define ZCCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ZCCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/zccr_pkg.sv
package zccr_pkg;

  // Sample history.
  localparam int unsigned HIST_DEPTH = 256;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
  localparam int unsigned SAMPLE_W   = 16;

  // Pulse count and quotient widths.
  localparam int unsigned MAX_PULSES = 32;
  localparam int unsigned PULSE_W    = $clog2(MAX_PULSES + 1);
  localparam int unsigned QUO_W      = PULSE_W;
  localparam int unsigned DIVCNT_W   = $clog2(QUO_W);

  // Crossing gap counter and Q7.8 pulse length estimate.
  localparam int unsigned GAP_W   = 12;
  localparam int unsigned GAP_MAX = (1 << GAP_W) - 1;
  localparam int unsigned EST_W   = 15;
  localparam int unsigned EST_MAX = (1 << EST_W) - 1;

  // Derived arithmetic widths.
  localparam int unsigned STEP_W = 7;
  localparam int unsigned LOOK_W = STEP_W + PULSE_W - 1;
  localparam int unsigned BOUND_W = 16;
  localparam int unsigned C256_W  = GAP_W + 8;
  localparam int unsigned PRODA_W = EST_W + 8;
  localparam int unsigned PRODB_W = GAP_W + 9;
  localparam int unsigned SUM_W   = PRODB_W + 9;
  localparam int unsigned NUM_W   = GAP_W + 10;

  // Configuration registers.
  localparam int unsigned NOM_W     = 7;
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_TOL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA       = 2'd2;

  localparam logic [NOM_W-1:0]  NOMINAL_RST = 7'd8;
  localparam logic [FRAC_W-1:0] DRIFT_RST   = 8'd56;
  localparam logic [FRAC_W-1:0] ALPHA_RST   = 8'd230;

endpackage

>>> rtl/zero_crossing_clock_recovery.sv
// Zero-crossing timing recovery: one sample in, zero or more looked-back samples out.
// A sample without a sign change leaves the block idle, so such samples stream at one per cycle.
// A crossing goes through the range check, estimate update, six-step divider and a read
// before its first word, then gives two words per pulse; the next sample is taken only after
// the last word is loaded (or after the divider, with no pulses), and output stalls delay it.
// After reset a pass over all 256 entries zeroes the history memory; no sample is taken meanwhile.
`include "zero_crossing_clock_recovery_macros.svh"

module zero_crossing_clock_recovery (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Sample input
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [zccr_pkg::SAMPLE_W-1:0]   sample_in_i,
  // Result output
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [zccr_pkg::SAMPLE_W-1:0]   sample_out_o,
  output logic                                   last_of_run_o,
  // Configuration write
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [zccr_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [zccr_pkg::CFG_DAT_W-1:0]         cfg_data_i
);

  localparam int unsigned AW = zccr_pkg::HIST_AW;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_RANGE = 4'd2;
  localparam logic [3:0] ST_UPD1  = 4'd3;
  localparam logic [3:0] ST_UPD2  = 4'd4;
  localparam logic [3:0] ST_DINIT = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_READ  = 4'd7;
  localparam logic [3:0] ST_EMIT0 = 4'd8;
  localparam logic [3:0] ST_EMIT1 = 4'd9;

  // History memory.
  logic [zccr_pkg::SAMPLE_W-1:0] hist_mem [zccr_pkg::HIST_DEPTH];
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [zccr_pkg::SAMPLE_W-1:0] mem_wdata;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic [zccr_pkg::SAMPLE_W-1:0] rd_q;

  // Control state.
  logic [3:0]                          state_q, state_d;
  logic [AW-1:0]                       clr_idx_q, clr_idx_d;
  logic [AW-1:0]                       wr_q, wr_d;
  logic [zccr_pkg::GAP_W-1:0]          count_q, count_d;
  logic [zccr_pkg::EST_W-1:0]          est_q, est_d;
  logic                                prev_pos_q, prev_pos_d;
  logic [zccr_pkg::NOM_W-1:0]          nom_q, nom_d;
  logic [zccr_pkg::FRAC_W-1:0]         drift_q, drift_d;
  logic [zccr_pkg::FRAC_W-1:0]         alpha_q, alpha_d;
  logic [zccr_pkg::DIVCNT_W-1:0]       div_cnt_q, div_cnt_d;
  logic [zccr_pkg::PULSE_W-1:0]        pulses_q, pulses_d;
  logic [zccr_pkg::PULSE_W-1:0]        pulse_idx_q, pulse_idx_d;
  logic                                out_valid_q, out_valid_d;

  // Datapath registers.
  logic [zccr_pkg::BOUND_W-1:0]        lo_q, lo_d, hi_q, hi_d;
  logic [zccr_pkg::PRODA_W-1:0]        prod_a_q, prod_a_d;
  logic [zccr_pkg::PRODB_W-1:0]        prod_b_q, prod_b_d;
  logic                                in_range_q, in_range_d;
  logic [zccr_pkg::NUM_W-1:0]          rem_q, rem_d, dsh_q, dsh_d;
  logic [zccr_pkg::QUO_W-1:0]          quo_q, quo_d;
  logic                                sat_q, sat_d;
  logic [zccr_pkg::STEP_W-1:0]         step_q, step_d;
  logic [zccr_pkg::LOOK_W-1:0]         look_q, look_d;
  logic [zccr_pkg::SAMPLE_W-1:0]       out_sample_q, out_sample_d;
  logic                                out_last_q, out_last_d;

  // Helpers.
  logic                                in_acc, cfg_acc, sample_pos, crossing;
  logic                                out_free, out_load, is_last;
  logic [zccr_pkg::C256_W-1:0]         c256;
  logic [zccr_pkg::SUM_W-1:0]          est_sum;
  logic [zccr_pkg::SUM_W-9:0]          est_new;
  logic [zccr_pkg::NUM_W-1:0]          num_init, den_ext;
  logic [zccr_pkg::STEP_W+8:0]         step_sum;
  logic [zccr_pkg::LOOK_W-1:0]         look_nxt, rd_look;
  logic [AW-1:0]                       look_clamp;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign sample_pos  = !sample_in_i[zccr_pkg::SAMPLE_W-1];
  assign crossing    = (sample_pos != prev_pos_q);

  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = ((state_q == ST_EMIT0) || (state_q == ST_EMIT1)) && out_free;
  assign is_last  = (pulse_idx_q == (pulses_q - zccr_pkg::PULSE_W'(1)));

  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = out_sample_q;
  assign last_of_run_o = out_last_q;

  // Arithmetic shared by the update and divider stages.
  assign c256     = {count_q, 8'b0};
  assign est_sum  = zccr_pkg::SUM_W'(prod_a_q) + zccr_pkg::SUM_W'({prod_b_q, 8'b0})
                  + zccr_pkg::SUM_W'(128);
  assign est_new  = est_sum[zccr_pkg::SUM_W-1:8];
  assign num_init = zccr_pkg::NUM_W'({count_q, 9'b0}) + zccr_pkg::NUM_W'(est_q);
  assign den_ext  = zccr_pkg::NUM_W'({est_q, 1'b0});
  assign step_sum = (zccr_pkg::STEP_W+9)'(est_q) + (zccr_pkg::STEP_W+9)'(128);

  // Look-back distance of the read being issued, clamped to the oldest entry.
  assign look_nxt   = look_q + zccr_pkg::LOOK_W'(step_q);
  assign rd_look    = (state_q == ST_EMIT1) ? look_nxt : look_q;
  assign look_clamp = (rd_look > zccr_pkg::LOOK_W'(zccr_pkg::HIST_DEPTH - 1))
                    ? AW'(zccr_pkg::HIST_DEPTH - 1) : rd_look[AW-1:0];
  assign rd_addr    = wr_q - look_clamp;
  assign rd_en      = (state_q == ST_READ) || ((state_q == ST_EMIT1) && out_free && !is_last);

  // Memory write port: zeroing pass after reset, then one sample per accepted word.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_q + AW'(1);
    mem_wdata = sample_in_i;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_q;
      mem_wdata = '0;
    end else if (in_acc) begin
      mem_we = 1'b1;
    end
  end

  // Single write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q <= hist_mem[rd_addr];
    end
  end

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_d      = state_q;
    clr_idx_d    = clr_idx_q;
    wr_d         = wr_q;
    count_d      = count_q;
    est_d        = est_q;
    prev_pos_d   = prev_pos_q;
    nom_d        = nom_q;
    drift_d      = drift_q;
    alpha_d      = alpha_q;
    div_cnt_d    = div_cnt_q;
    pulses_d     = pulses_q;
    pulse_idx_d  = pulse_idx_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    prod_a_d     = prod_a_q;
    prod_b_d     = prod_b_q;
    in_range_d   = in_range_q;
    rem_d        = rem_q;
    dsh_d        = dsh_q;
    quo_d        = quo_q;
    sat_d        = sat_q;
    step_d       = step_q;
    look_d       = look_q;
    out_sample_d = rd_q;
    out_last_d   = (state_q == ST_EMIT1) && is_last;

    // Output register: a loaded word replaces one that is being taken.
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // Configuration writes; the nominal length also reloads the estimate.
    if (cfg_acc) begin
      unique case (cfg_index_i)
        zccr_pkg::CFG_NOMINAL_LEN: begin
          nom_d = cfg_data_i[zccr_pkg::NOM_W-1:0];
          est_d = {cfg_data_i[zccr_pkg::NOM_W-1:0], 8'b0};
        end
        zccr_pkg::CFG_DRIFT_TOL: drift_d = cfg_data_i;
        zccr_pkg::CFG_ALPHA:     alpha_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_CLEAR: begin
        clr_idx_d = clr_idx_q + AW'(1);
        if (clr_idx_q == AW'(zccr_pkg::HIST_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      // Take a sample, bump the gap count and look for a sign change.
      ST_IDLE: begin
        if (in_acc) begin
          wr_d       = wr_q + AW'(1);
          prev_pos_d = sample_pos;
          if (count_q != zccr_pkg::GAP_W'(zccr_pkg::GAP_MAX)) begin
            count_d = count_q + zccr_pkg::GAP_W'(1);
          end
          if (crossing) begin
            state_d = ST_RANGE;
          end
        end
      end

      // Window bounds around the nominal length.
      ST_RANGE: begin
        lo_d = zccr_pkg::BOUND_W'(nom_q) * zccr_pkg::BOUND_W'(9'd256 - {1'b0, drift_q});
        hi_d = zccr_pkg::BOUND_W'(nom_q) * zccr_pkg::BOUND_W'(9'd256 + {1'b0, drift_q});
        state_d = ST_UPD1;
      end

      // Range check and the two products of the smoothing filter.
      ST_UPD1: begin
        in_range_d = (c256 > zccr_pkg::C256_W'(lo_q)) && (c256 < zccr_pkg::C256_W'(hi_q));
        prod_a_d   = zccr_pkg::PRODA_W'(est_q) * zccr_pkg::PRODA_W'(alpha_q);
        prod_b_d   = zccr_pkg::PRODB_W'(count_q)
                   * zccr_pkg::PRODB_W'(9'd256 - {1'b0, alpha_q});
        state_d    = ST_UPD2;
      end

      // Rounded, saturated estimate update when the gap is in range.
      ST_UPD2: begin
        if (in_range_q) begin
          if (est_new > (zccr_pkg::SUM_W-8)'(zccr_pkg::EST_MAX)) begin
            est_d = zccr_pkg::EST_W'(zccr_pkg::EST_MAX);
          end else begin
            est_d = est_new[zccr_pkg::EST_W-1:0];
          end
        end
        state_d = ST_DINIT;
      end

      // Divider setup; a quotient that would not fit is flagged here and saturates when the division ends.
      ST_DINIT: begin
        rem_d     = num_init;
        dsh_d     = den_ext << (zccr_pkg::QUO_W - 1);
        sat_d     = (num_init >= (den_ext << zccr_pkg::QUO_W));
        quo_d     = '0;
        div_cnt_d = '0;
        step_d    = step_sum[zccr_pkg::STEP_W+8:9];
        state_d   = ST_DIV;
      end

      // Restoring division, one quotient bit per cycle.
      ST_DIV: begin
        if (rem_q >= dsh_q) begin
          rem_d = rem_q - dsh_q;
          quo_d = {quo_q[zccr_pkg::QUO_W-2:0], 1'b1};
        end else begin
          quo_d = {quo_q[zccr_pkg::QUO_W-2:0], 1'b0};
        end
        dsh_d     = dsh_q >> 1;
        div_cnt_d = div_cnt_q + zccr_pkg::DIVCNT_W'(1);
        if (div_cnt_q == zccr_pkg::DIVCNT_W'(zccr_pkg::QUO_W - 1)) begin
          if (sat_q || (quo_d > zccr_pkg::QUO_W'(zccr_pkg::MAX_PULSES))) begin
            pulses_d = zccr_pkg::PULSE_W'(zccr_pkg::MAX_PULSES);
          end else begin
            pulses_d = quo_d;
          end
          pulse_idx_d = '0;
          look_d      = zccr_pkg::LOOK_W'(step_q);
          if (pulses_d == '0) begin
            count_d = '0;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_READ;
          end
        end
      end

      ST_READ: begin
        state_d = ST_EMIT0;
      end

      // First copy of the looked-back sample.
      ST_EMIT0: begin
        if (out_free) begin
          state_d = ST_EMIT1;
        end
      end

      // Second copy; the next pulse's read goes out in the same cycle.
      ST_EMIT1: begin
        if (out_free) begin
          if (is_last) begin
            count_d = '0;
            state_d = ST_IDLE;
          end else begin
            pulse_idx_d = pulse_idx_q + zccr_pkg::PULSE_W'(1);
            look_d      = look_nxt;
            state_d     = ST_EMIT0;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      wr_q        <= '0;
      count_q     <= '0;
      est_q       <= {zccr_pkg::NOMINAL_RST, 8'b0};
      prev_pos_q  <= 1'b1;
      nom_q       <= zccr_pkg::NOMINAL_RST;
      drift_q     <= zccr_pkg::DRIFT_RST;
      alpha_q     <= zccr_pkg::ALPHA_RST;
      div_cnt_q   <= '0;
      pulses_q    <= '0;
      pulse_idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      wr_q        <= wr_d;
      count_q     <= count_d;
      est_q       <= est_d;
      prev_pos_q  <= prev_pos_d;
      nom_q       <= nom_d;
      drift_q     <= drift_d;
      alpha_q     <= alpha_d;
      div_cnt_q   <= div_cnt_d;
      pulses_q    <= pulses_d;
      pulse_idx_q <= pulse_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    prod_a_q   <= prod_a_d;
    prod_b_q   <= prod_b_d;
    in_range_q <= in_range_d;
    rem_q      <= rem_d;
    dsh_q      <= dsh_d;
    quo_q      <= quo_d;
    sat_q      <= sat_d;
    step_q     <= step_d;
    look_q     <= look_d;
    if (out_load) begin
      out_sample_q <= out_sample_d;
      out_last_q   <= out_last_d;
    end
  end

  // A sample without a sign change never leaves the idle state.
  `ZCCR_ASSERT_NEXT(a_quiet_sample, in_acc && !crossing, state_q == ST_IDLE,
                    "sample without crossing left idle")

  // The final word of a run ends the burst and clears the gap count.
  `ZCCR_ASSERT_NEXT(a_last_ends_run, out_load && out_last_d,
                    state_q == ST_IDLE && count_q == '0,
                    "last word did not return to idle with a cleared count")

  // The pulse index stays below the pulse count while words go out.
  `ZCCR_ASSERT(a_pulse_idx_range,
               (state_q == ST_EMIT0 || state_q == ST_EMIT1) |-> (pulse_idx_q < pulses_q),
               "pulse index ran past the pulse count")

endmodule
